@@ hdl/hrgb_pkg.sv @@
// Shared widths, constants and types for the hue angle to RGB LED converter.
// No dependencies; every other file of the block imports this package.
package hrgb_pkg;

   localparam int HUE_W    = 16;
   localparam int LEVEL_W  = 8;
   localparam int WRAP_W   = 9;   // reduced hue 0..359
   localparam int REM_W    = 6;   // remainder 0..59
   localparam int PROD_W   = 14;  // brightness * (0..60) <= 15300

   localparam logic [WRAP_W-1:0] FULL_TURN      = 9'd360;
   localparam logic [REM_W-1:0]  SECTOR_DEGREES = 6'd60;

   // Bias that moves any signed 16-bit angle into a nonnegative 17-bit range
   // while keeping its value modulo 360 (92 full turns).
   localparam logic [HUE_W:0] HUE_BIAS = 17'd33120;

   // Reciprocal multipliers, exact floors over the value ranges used here.
   localparam int            RECIP_360_SHIFT = 24;
   localparam logic [15:0]   RECIP_360       = 16'd46604;
   localparam int            RECIP_60_SHIFT  = 20;
   localparam logic [14:0]   RECIP_60        = 15'd17477;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [WRAP_W-1:0]  wrap_type;
   typedef logic [REM_W-1:0]   rem_type;
   typedef logic [PROD_W-1:0]  prod_type;

   // 60-degree sectors of the color wheel
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

@@ hdl/hrgb_if.sv @@
// Valid/ready channel interfaces for hue requests and RGB level responses.
// Depends on hrgb_pkg for field widths.
interface hrgb_req_if import hrgb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [HUE_W-1:0]  hue_degrees;
   level_type                brightness;

   modport source (output valid, output hue_degrees, output brightness, input ready);
   modport sink   (input valid, input hue_degrees, input brightness, output ready);
endinterface

interface hrgb_rsp_if import hrgb_pkg::*; ();
   logic       valid;
   logic       ready;
   level_type  red_level;
   level_type  green_level;
   level_type  blue_level;

   modport source (output valid, output red_level, output green_level, output blue_level,
                   input ready);
   modport sink   (input valid, input red_level, input green_level, input blue_level,
                   output ready);
endinterface

@@ hdl/hue_angle_to_rgb_led_core.sv @@
// Top level: full-saturation hue/brightness to RGB level converter.
// Depends on hrgb_pkg, hrgb_if and hrgb_hue_wrap.
//
//   channel   dir   handshake      payload
//   req       in    valid/ready    hue_degrees (s16), brightness (u8)
//   rsp       out   valid/ready    red_level, green_level, blue_level (u8)
//
// Six register stages: two for the modulo-360 reduction, then sector split,
// channel products, reciprocal multiply by 1/60, and the output register.
// One request per cycle while rsp is not stalled; each stage holds under stall and
// takes a new request as soon as the stage after it moves, so bubbles close up.
// Synchronous reset clears the valid bits only.
module hue_angle_to_rgb_led_core import hrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hrgb_req_if.sink    req,
   hrgb_rsp_if.source  rsp
);

   logic        w_valid;
   logic        w_ready;
   wrap_type    w_hue;
   level_type   w_bright;

   logic        c_valid_ff;
   sector_type  c_sector_ff;
   rem_type     c_rem_ff;
   level_type   c_bright_ff;

   logic        d_valid_ff;
   sector_type  d_sector_ff;
   prod_type    d_rise_ff;
   prod_type    d_fall_ff;
   level_type   d_bright_ff;

   logic        e_valid_ff;
   sector_type  e_sector_ff;
   logic [28:0] e_rise_ff;
   logic [28:0] e_fall_ff;
   level_type   e_bright_ff;

   logic        f_valid_ff;
   level_type   f_red_ff;
   level_type   f_green_ff;
   level_type   f_blue_ff;

   logic        c_ready;
   logic        d_ready;
   logic        e_ready;
   logic        f_ready;

   sector_type  c_sector_in;
   wrap_type    c_offset;
   wrap_type    c_rem_full;
   rem_type     d_comp;
   level_type   rise;
   level_type   fall;
   level_type   f_red_in;
   level_type   f_green_in;
   level_type   f_blue_in;

   hrgb_hue_wrap u_wrap (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req.valid),
      .in_ready       (req.ready),
      .in_hue         (req.hue_degrees),
      .in_brightness  (req.brightness),
      .out_valid      (w_valid),
      .out_ready      (w_ready),
      .out_hue        (w_hue),
      .out_brightness (w_bright)
   );

   assign f_ready = !f_valid_ff || rsp.ready;
   assign e_ready = !e_valid_ff || f_ready;
   assign d_ready = !d_valid_ff || e_ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign w_ready = c_ready;

   // Sector by threshold compare; highest threshold wins.
   always_comb begin
      priority if (w_hue >= 9'd300) begin
         c_sector_in = SECTOR_MAGENTA_RED;
         c_offset    = 9'd300;
      end else if (w_hue >= 9'd240) begin
         c_sector_in = SECTOR_BLUE_MAGENTA;
         c_offset    = 9'd240;
      end else if (w_hue >= 9'd180) begin
         c_sector_in = SECTOR_CYAN_BLUE;
         c_offset    = 9'd180;
      end else if (w_hue >= 9'd120) begin
         c_sector_in = SECTOR_GREEN_CYAN;
         c_offset    = 9'd120;
      end else if (w_hue >= 9'd60) begin
         c_sector_in = SECTOR_YELLOW_GREEN;
         c_offset    = 9'd60;
      end else begin
         c_sector_in = SECTOR_RED_YELLOW;
         c_offset    = 9'd0;
      end
   end

   assign c_rem_full = w_hue - c_offset;
   assign d_comp     = SECTOR_DEGREES - c_rem_ff;

   assign rise = e_rise_ff[RECIP_60_SHIFT+7:RECIP_60_SHIFT];
   assign fall = e_fall_ff[RECIP_60_SHIFT+7:RECIP_60_SHIFT];

   always_comb begin
      unique case (e_sector_ff)
         SECTOR_RED_YELLOW: begin
            f_red_in = e_bright_ff; f_green_in = rise; f_blue_in = '0;
         end
         SECTOR_YELLOW_GREEN: begin
            f_red_in = fall; f_green_in = e_bright_ff; f_blue_in = '0;
         end
         SECTOR_GREEN_CYAN: begin
            f_red_in = '0; f_green_in = e_bright_ff; f_blue_in = rise;
         end
         SECTOR_CYAN_BLUE: begin
            f_red_in = '0; f_green_in = fall; f_blue_in = e_bright_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            f_red_in = rise; f_green_in = '0; f_blue_in = e_bright_ff;
         end
         default: begin
            f_red_in = e_bright_ff; f_green_in = '0; f_blue_in = fall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (c_ready) c_valid_ff <= w_valid;
         if (d_ready) d_valid_ff <= c_valid_ff;
         if (e_ready) e_valid_ff <= d_valid_ff;
         if (f_ready) f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_sector_ff <= c_sector_in;
         c_rem_ff    <= c_rem_full[REM_W-1:0];
         c_bright_ff <= w_bright;
      end
      if (d_ready) begin
         d_sector_ff <= c_sector_ff;
         d_rise_ff   <= {6'd0, c_bright_ff} * {8'd0, c_rem_ff};
         d_fall_ff   <= {6'd0, c_bright_ff} * {8'd0, d_comp};
         d_bright_ff <= c_bright_ff;
      end
      if (e_ready) begin
         e_sector_ff <= d_sector_ff;
         e_rise_ff   <= {15'd0, d_rise_ff} * {14'd0, RECIP_60};
         e_fall_ff   <= {15'd0, d_fall_ff} * {14'd0, RECIP_60};
         e_bright_ff <= d_bright_ff;
      end
      if (f_ready) begin
         f_red_ff   <= f_red_in;
         f_green_ff <= f_green_in;
         f_blue_ff  <= f_blue_in;
      end
   end

   assign rsp.valid       = f_valid_ff;
   assign rsp.red_level   = f_red_ff;
   assign rsp.green_level = f_green_ff;
   assign rsp.blue_level  = f_blue_ff;

endmodule

@@ hdl/hrgb_hue_wrap.sv @@
// Two-stage pipeline that reduces a signed hue angle to 0..359.
// Depends on hrgb_pkg; brightness rides along with the angle.
module hrgb_hue_wrap import hrgb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [HUE_W-1:0] in_hue,
   input  level_type               in_brightness,
   output logic                    out_valid,
   input  logic                    out_ready,
   output wrap_type                out_hue,
   output level_type               out_brightness
);

   logic              a_valid_ff;
   logic [HUE_W:0]    a_biased_ff;
   logic [31:0]       a_prod_ff;
   level_type         a_bright_ff;
   logic              b_valid_ff;
   wrap_type          b_hue_ff;
   level_type         b_bright_ff;

   logic              a_ready;
   logic              b_ready;
   logic [HUE_W:0]    biased_in;
   logic [7:0]        quot;
   logic [16:0]       turns;
   logic [HUE_W:0]    wrapped;
   wrap_type          b_hue_in;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Shift into the nonnegative range without changing the angle mod 360.
   assign biased_in = {in_hue[HUE_W-1], in_hue} + HUE_BIAS;

   assign quot     = a_prod_ff[RECIP_360_SHIFT+7:RECIP_360_SHIFT];
   assign turns    = {9'd0, quot} * {8'd0, FULL_TURN};
   assign wrapped  = a_biased_ff - turns;
   assign b_hue_in = wrapped[WRAP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_biased_ff <= biased_in;
         a_prod_ff   <= {15'd0, biased_in} * {16'd0, RECIP_360};
         a_bright_ff <= in_brightness;
      end
      if (b_ready) begin
         b_hue_ff    <= b_hue_in;
         b_bright_ff <= a_bright_ff;
      end
   end

   assign out_valid      = b_valid_ff;
   assign out_hue        = b_hue_ff;
   assign out_brightness = b_bright_ff;

endmodule
